// ----- rtl/core/chkre_pkg.sv -----
`timescale 1ns / 1ps
// shared types, widths and codes for the chunk reassembly block
// no dependencies; used by chkre_ctrl, chkre_dp and the top level

package chkre_pkg;

    // default sizes
    localparam int STAGING_BYTES_DEF   = 1024;
    localparam int MAX_CHUNK_BYTES_DEF = 64;

    // fixed field widths
    localparam int CMD_W      = 2;
    localparam int OFFSET_W   = 11;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    // item commands
    localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BYTE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_EMPTY  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CONFLICT   = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic                accept;
        logic                clr_step;
        logic                idx_clr;
        logic                idx_inc;
        logic                chk_rd;
        logic                wr_rd;
        logic                wr_wr;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic item_ctl;
        logic item_apply;
        logic clr_last;
        logic session;
        logic range_err;
        logic len_zero;
        logic conflict;
        logic idx_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/core/chunk_reassembly_with_conflict_check_top.sv -----
`timescale 1ns / 1ps
// top level of the chunk reassembly block with conflict check
// depends on chkre_pkg, chkre_ctrl and chkre_dp
//
// channel   | dir | carries
// ----------+-----+--------------------------------------------------------
// s_t*      | in  | command (tuser), chunk offset and byte (tdata), last byte
// m_t*      | out | status, covered count, complete and active flags (tdata)
//
// a chunk byte that is not last is taken while the block stays idle; an item
// that ends a chunk runs a check pass (read, compare) and then a write pass
// (read, write) over each byte of the single-port store and coverage rows,
// or is rejected before the passes; begin and cancel run the coverage
// clearing pass, and after reset the same pass runs before the first transfer
// is taken; a stalled result holds the block only when the next chunk ends

module chunk_reassembly_with_conflict_check_top
    import chkre_pkg::*;
#(
    parameter int STAGING_BYTES   = STAGING_BYTES_DEF,
    parameter int MAX_CHUNK_BYTES = MAX_CHUNK_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // chunk_offset[10:0], data_byte[18:11], zero
    input  logic [CMD_W-1:0]       s_tuser,   // command[1:0]
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // status[1:0], received_count[12:2],
                                              // staging_complete[13], staging_active[14], zero
);

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  received_count;
    logic                staging_complete;
    logic                staging_active;

    // sequencing
    chkre_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // storage and arithmetic
    chkre_dp #(
        .STAGING_BYTES   (STAGING_BYTES),
        .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_command   (s_tuser),
        .in_offset    (s_tdata[OFFSET_W-1:0]),
        .in_byte      (s_tdata[OFFSET_W+BYTE_W-1:OFFSET_W]),
        .in_last      (s_tlast),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (status),
        .out_count    (received_count),
        .out_complete (staging_complete),
        .out_active   (staging_active)
    );

    // result packing
    assign m_tdata = {1'b0, staging_active, staging_complete, received_count, status};

endmodule

// ----- rtl/core/chkre_dp.sv -----
`timescale 1ns / 1ps
// datapath: staging store, coverage rows, pending chunk buffer, counters
// and the result register; depends on chkre_pkg

module chkre_dp
    import chkre_pkg::*;
#(
    parameter int STAGING_BYTES   = STAGING_BYTES_DEF,
    parameter int MAX_CHUNK_BYTES = MAX_CHUNK_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [CMD_W-1:0]    in_command,
    input  logic [OFFSET_W-1:0] in_offset,
    input  logic [BYTE_W-1:0]   in_byte,
    input  logic                in_last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [COUNT_W-1:0]  out_count,
    output logic                out_complete,
    output logic                out_active
);

    localparam int ROW_BITS = 8;
    localparam int BSEL_W   = $clog2(ROW_BITS);
    localparam int SIDX_W   = $clog2(STAGING_BYTES);
    localparam int ROW_W    = SIDX_W - BSEL_W;
    localparam int COV_ROWS = (STAGING_BYTES + ROW_BITS - 1) / ROW_BITS;
    localparam int CNT_W    = $clog2(STAGING_BYTES + 1);
    localparam int CMP_W    = ((CNT_W > OFFSET_W) ? CNT_W : OFFSET_W) + 1;
    localparam int PIDX_W   = (MAX_CHUNK_BYTES > 1) ? $clog2(MAX_CHUNK_BYTES) : 1;
    localparam int PLEN_W   = $clog2(MAX_CHUNK_BYTES + 1);
    localparam int LCMP_W   = PLEN_W + 1;

    // memories
    logic [BYTE_W-1:0]   staged_mem [STAGING_BYTES];
    logic [ROW_BITS-1:0] cov_mem    [COV_ROWS];
    logic [BYTE_W-1:0]   pend_mem   [MAX_CHUNK_BYTES];

    // control registers
    logic                session_reg, session_next;
    logic [CNT_W-1:0]    cnt_reg,     cnt_next;
    logic [PLEN_W-1:0]   len_reg,     len_next;
    logic                ovf_reg,     ovf_next;
    logic [OFFSET_W-1:0] off_reg,     off_next;
    logic [PIDX_W-1:0]   idx_reg,     idx_next;
    logic [ROW_W-1:0]    clr_reg,     clr_next;
    logic                out_valid_reg, out_valid_next;

    // read data and result payload
    logic [BYTE_W-1:0]   staged_rd_reg;
    logic [BYTE_W-1:0]   pend_rd_reg;
    logic [ROW_BITS-1:0] cov_rd_reg;
    logic [BSEL_W-1:0]   bsel_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_complete_reg;
    logic                out_active_reg;

    logic [CMP_W-1:0]    sum_wide;
    logic [CMP_W-1:0]    cnt_wide;
    logic [SIDX_W-1:0]   sidx;
    logic [ROW_W-1:0]    row;
    logic [BSEL_W-1:0]   bsel;
    logic                cov_bit;
    logic                len_room;
    logic                pend_wr;

    // staging address of the current chunk byte
    assign sum_wide = CMP_W'(off_reg) + CMP_W'(idx_reg);
    assign sidx     = sum_wide[SIDX_W-1:0];
    assign row      = sidx[SIDX_W-1:BSEL_W];
    assign bsel     = sidx[BSEL_W-1:0];
    assign cov_bit  = cov_rd_reg[bsel_reg];
    assign len_room = len_reg < PLEN_W'(MAX_CHUNK_BYTES);
    assign pend_wr  = cmd.accept && (in_command == CMD_BYTE) && len_room;
    assign cnt_wide = CMP_W'(cnt_reg);

    // status towards the controller
    always_comb
    begin
        stat.item_ctl   = (in_command == CMD_BEGIN) || (in_command == CMD_CANCEL);
        stat.item_apply = ((in_command == CMD_BYTE) && in_last) || (in_command == CMD_EMPTY);
        stat.clr_last   = clr_reg == ROW_W'(COV_ROWS - 1);
        stat.session    = session_reg;
        stat.range_err  = ovf_reg
                       || (CMP_W'(off_reg) > CMP_W'(STAGING_BYTES))
                       || (CMP_W'(len_reg) > (CMP_W'(STAGING_BYTES) - CMP_W'(off_reg)));
        stat.len_zero   = len_reg == '0;
        stat.conflict   = cov_bit && (staged_rd_reg != pend_rd_reg);
        stat.idx_last   = (LCMP_W'(idx_reg) + LCMP_W'(1)) == LCMP_W'(len_reg);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // next state of the control registers
    always_comb
    begin
        session_next   = session_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        off_next       = off_reg;
        idx_next       = idx_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;

        if (cmd.accept)
        begin
            case (in_command)
                CMD_BEGIN:
                begin
                    session_next = 1'b1;
                    cnt_next     = '0;
                    len_next     = '0;
                    ovf_next     = 1'b0;
                end
                CMD_CANCEL:
                begin
                    session_next = 1'b0;
                    cnt_next     = '0;
                    len_next     = '0;
                    ovf_next     = 1'b0;
                end
                CMD_BYTE:
                begin
                    if (len_room)
                        len_next = len_reg + PLEN_W'(1);
                    else
                        ovf_next = 1'b1;
                    off_next = in_offset;
                end
                CMD_EMPTY:
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                    off_next = in_offset;
                end
                default: ;
            endcase
        end

        // newly covered byte
        if (cmd.wr_wr && !cov_bit)
            cnt_next = cnt_reg + CNT_W'(1);

        // chunk is done with, drop it
        if (cmd.res_load)
        begin
            len_next = '0;
            ovf_next = 1'b0;
        end

        if (cmd.idx_clr)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + PIDX_W'(1);

        if (cmd.clr_step)
            clr_next = stat.clr_last ? '0 : clr_reg + ROW_W'(1);

        if (cmd.res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg   <= 1'b0;
            cnt_reg       <= '0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            off_reg       <= '0;
            idx_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            session_reg   <= session_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            off_reg       <= off_next;
            idx_reg       <= idx_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // pending chunk buffer
    always_ff @(posedge clk)
    begin
        if (pend_wr)
            pend_mem[len_reg[PIDX_W-1:0]] <= in_byte;
        if (cmd.chk_rd || cmd.wr_rd)
            pend_rd_reg <= pend_mem[idx_reg];
    end

    // staging store
    always_ff @(posedge clk)
    begin
        if (cmd.wr_wr)
            staged_mem[sidx] <= pend_rd_reg;
        if (cmd.chk_rd)
            staged_rd_reg <= staged_mem[sidx];
    end

    // coverage rows, cleared one row a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            cov_mem[clr_reg] <= '0;
        else if (cmd.wr_wr)
            cov_mem[row] <= cov_rd_reg | (ROW_BITS'(1) << bsel_reg);
        if (cmd.chk_rd || cmd.wr_rd)
        begin
            cov_rd_reg <= cov_mem[row];
            bsel_reg   <= bsel;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_status_reg   <= cmd.res_status;
            out_count_reg    <= cnt_wide[COUNT_W-1:0];
            out_complete_reg <= cnt_reg == CNT_W'(STAGING_BYTES);
            out_active_reg   <= session_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_count    = out_count_reg;
    assign out_complete = out_complete_reg;
    assign out_active   = out_active_reg;

    // checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(STAGING_BYTES))
        else $error("covered count beyond staging size");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (len_reg == PLEN_W'(MAX_CHUNK_BYTES)))
        else $error("overflow flagged with room left in pending buffer");

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_wr |-> (sum_wide < CMP_W'(STAGING_BYTES)))
        else $error("store write beyond staging buffer");

endmodule

// ----- rtl/core/chkre_ctrl.sv -----
`timescale 1ns / 1ps
// controller: sequences clearing passes, the check pass and the write pass
// of a chunk, and the handover of results; depends on chkre_pkg

module chkre_ctrl
    import chkre_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    localparam logic [2:0] FSM_CLEAR   = 3'd0;
    localparam logic [2:0] FSM_IDLE    = 3'd1;
    localparam logic [2:0] FSM_CHECK   = 3'd2;
    localparam logic [2:0] FSM_CHK_RD  = 3'd3;
    localparam logic [2:0] FSM_CHK_CMP = 3'd4;
    localparam logic [2:0] FSM_WR_RD   = 3'd5;
    localparam logic [2:0] FSM_WR_WR   = 3'd6;
    localparam logic [2:0] FSM_DONE    = 3'd7;

    logic [2:0]          state_reg,  state_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                accept;

    assign s_tready = state_reg == FSM_IDLE;
    assign accept   = s_tvalid && s_tready;

    // sequencing
    always_comb
    begin
        cmd         = '0;
        cmd.accept  = accept;
        state_next  = state_reg;
        status_next = status_reg;

        case (state_reg)
            FSM_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = FSM_IDLE;
            end
            FSM_IDLE:
            begin
                if (accept)
                begin
                    if (stat.item_ctl)
                        state_next = FSM_CLEAR;
                    else if (stat.item_apply)
                        state_next = FSM_CHECK;
                end
            end
            FSM_CHECK:
            begin
                cmd.idx_clr = 1'b1;
                if (!stat.session)
                begin
                    status_next = ST_NOT_ACTIVE;
                    state_next  = FSM_DONE;
                end
                else if (stat.range_err)
                begin
                    status_next = ST_RANGE;
                    state_next  = FSM_DONE;
                end
                else if (stat.len_zero)
                begin
                    status_next = ST_OK;
                    state_next  = FSM_DONE;
                end
                else
                    state_next = FSM_CHK_RD;
            end
            FSM_CHK_RD:
            begin
                cmd.chk_rd = 1'b1;
                state_next = FSM_CHK_CMP;
            end
            FSM_CHK_CMP:
            begin
                if (stat.conflict)
                begin
                    status_next = ST_CONFLICT;
                    state_next  = FSM_DONE;
                end
                else if (stat.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = FSM_WR_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = FSM_CHK_RD;
                end
            end
            FSM_WR_RD:
            begin
                cmd.wr_rd  = 1'b1;
                state_next = FSM_WR_WR;
            end
            FSM_WR_WR:
            begin
                cmd.wr_wr = 1'b1;
                if (stat.idx_last)
                begin
                    status_next = ST_OK;
                    state_next  = FSM_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = FSM_WR_RD;
                end
            end
            FSM_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = status_reg;
                    state_next     = FSM_IDLE;
                end
            end
            default:
                state_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FSM_CLEAR;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    // checks
    a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_CHK_CMP) |-> ($past(state_reg) == FSM_CHK_RD))
        else $error("compare without preceding read");

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_WR_WR) |-> ($past(state_reg) == FSM_WR_RD))
        else $error("store write without preceding read");

    a_load_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> (state_reg == FSM_IDLE))
        else $error("no return to idle after result load");

endmodule

// ----- test/tb_chunk_reassembly_with_conflict_check_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for chunk_reassembly_with_conflict_check_top
// depends on chkre_pkg and the rtl below the top level; no files or arguments

import chkre_pkg::*;

// one result transfer, split into its fields
typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                complete;
    logic                active;
} chunk_result_t;

// predicts the staging state and holds the results still owed by the block
class chunk_scoreboard;
    logic [BYTE_W-1:0] staged [STAGING_BYTES_DEF];
    bit                covered [STAGING_BYTES_DEF];
    int unsigned       covered_total;
    bit                session_open;
    logic [BYTE_W-1:0] pending [MAX_CHUNK_BYTES_DEF];
    int unsigned       pending_len;
    bit                pending_overrun;
    chunk_result_t     expected_q[$];
    int unsigned       failures;

    // begin and cancel both forget the coverage and any partial chunk
    function void clear_coverage();
        foreach (covered[i])
            covered[i] = 1'b0;
        covered_total   = 0;
        pending_len     = 0;
        pending_overrun = 1'b0;
    endfunction

    function void note_transfer(logic [CMD_W-1:0] cmd, logic [OFFSET_W-1:0] offset,
                                logic [BYTE_W-1:0] data, logic last);
        int unsigned         base;
        int unsigned         i;
        logic [STATUS_W-1:0] st;
        chunk_result_t       res;
        base = offset;
        if (cmd == CMD_BEGIN || cmd == CMD_CANCEL)
        begin
            clear_coverage();
            session_open = (cmd == CMD_BEGIN);
            return;
        end
        if (cmd == CMD_BYTE)
        begin
            // bytes past the pending buffer are dropped and spoil the chunk
            if (pending_len < MAX_CHUNK_BYTES_DEF)
            begin
                pending[pending_len] = data;
                pending_len++;
            end
            else
                pending_overrun = 1'b1;
            if (!last)
                return;
        end
        else
        begin
            pending_len     = 0;
            pending_overrun = 1'b0;
        end

        // whole-chunk checks: inactive, then range, then conflict
        if (!session_open)
            st = ST_NOT_ACTIVE;
        else if (pending_overrun || base > STAGING_BYTES_DEF ||
                 pending_len > STAGING_BYTES_DEF - base)
            st = ST_RANGE;
        else
        begin
            st = ST_OK;
            for (i = 0; i < pending_len; i++)
                if (covered[base + i] && staged[base + i] !== pending[i])
                    st = ST_CONFLICT;
            if (st == ST_OK)
                for (i = 0; i < pending_len; i++)
                begin
                    if (!covered[base + i])
                    begin
                        covered[base + i] = 1'b1;
                        covered_total++;
                    end
                    staged[base + i] = pending[i];
                end
        end
        pending_len     = 0;
        pending_overrun = 1'b0;

        res.status   = st;
        res.count    = covered_total[COUNT_W-1:0];
        res.complete = (covered_total == STAGING_BYTES_DEF);
        res.active   = session_open;
        expected_q.push_back(res);
    endfunction

    function void check_result(chunk_result_t got);
        chunk_result_t want;
        if (expected_q.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("unexpected result: status %0d count %0d complete %0d active %0d",
                         got.status, got.count, got.complete, got.active);
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status || got.count !== want.count ||
            got.complete !== want.complete || got.active !== want.active)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("result mismatch: expected status %0d count %0d complete %0d active %0d",
                         want.status, want.count, want.complete, want.active);
                $display("                 got      status %0d count %0d complete %0d active %0d",
                         got.status, got.count, got.complete, got.active);
            end
        end
    endfunction
endclass

module tb_chunk_reassembly_with_conflict_check_top;

    localparam int ITEM_TARGET  = 1750;
    localparam int HOLD_AT_ITEM = 700;
    localparam int HOLD_CYCLES  = 600;
    localparam int SETTLE       = 300;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int OFFSET_MAX   = (1 << OFFSET_W) - 1;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]       s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    chunk_scoreboard   sb;
    logic [BYTE_W-1:0] image [STAGING_BYTES_DEF];
    int unsigned       items_sent;
    bit                no_idle;
    logic              holding;

    chunk_reassembly_with_conflict_check_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, the odd long one, none in quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // data that chunks of one session agree on
    task automatic refresh_image();
        foreach (image[i])
            image[i] = BYTE_W'($urandom);
    endtask

    // offer one item and wait for its transfer
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [OFFSET_W-1:0] offset,
                             input logic [BYTE_W-1:0] data, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_TDATA_W - OFFSET_W - BYTE_W){1'b0}}, data, offset};
        s_tlast  <= last;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        sb.note_transfer(cmd, offset, data, last);
        items_sent++;
    endtask

    // begin, cancel or empty chunk with noise on the unused fields
    task automatic send_control(input logic [CMD_W-1:0] cmd, input int unsigned offset);
        send_item(cmd, OFFSET_W'(offset), BYTE_W'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // chunk bytes taken from the image; the offset only counts on the last byte
    task automatic send_chunk(input int unsigned offset, input int unsigned len,
                              input bit spoil, input bit closed);
        int unsigned       i;
        int unsigned       bad;
        logic [BYTE_W-1:0] data;
        bit                end_here;
        bad = spoil ? $urandom_range(0, len - 1) : len;
        for (i = 0; i < len; i++)
        begin
            data = image[(offset + i) % STAGING_BYTES_DEF];
            if (i == bad)
                data = data ^ BYTE_W'($urandom_range(1, 255));
            end_here = closed && (i == len - 1);
            send_item(CMD_BYTE,
                      OFFSET_W'(end_here ? offset : $urandom_range(0, OFFSET_MAX)),
                      data, end_here);
        end
    endtask

    // stop offering and wait for every owed result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_q.size() != 0);
    endtask

    // session of mixed chunks: good, overlapping, edge, overrun, far, empty, aborted
    task automatic random_session();
        int unsigned choice;
        int unsigned kind;
        int unsigned len;
        int unsigned offset;
        choice = $urandom_range(0, 9);
        if (choice < 8)
        begin
            send_control(CMD_BEGIN, $urandom_range(0, OFFSET_MAX));
            if ($urandom_range(0, 1))
                refresh_image();
        end
        else if (choice == 8)
            send_control(CMD_CANCEL, $urandom_range(0, OFFSET_MAX));
        repeat ($urandom_range(3, 20))
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_CHUNK_BYTES_DEF)
                                                  : $urandom_range(1, 8);
                offset = $urandom_range(0, 1) ? $urandom_range(0, 95)
                                              : $urandom_range(0, STAGING_BYTES_DEF - len);
                send_chunk(offset, len, $urandom_range(0, 6) == 0, 1'b1);
            end
            else if (kind < 70)
            begin
                // at or across the end of the staging buffer
                len = $urandom_range(1, 8);
                offset = STAGING_BYTES_DEF - len + $urandom_range(0, len);
                send_chunk(offset, len, 1'b0, 1'b1);
            end
            else if (kind < 75)
                send_chunk($urandom_range(0, 200),
                           $urandom_range(MAX_CHUNK_BYTES_DEF + 1, MAX_CHUNK_BYTES_DEF + 8),
                           1'b0, 1'b1);
            else if (kind < 80)
                send_chunk($urandom_range(STAGING_BYTES_DEF + 1, OFFSET_MAX),
                           $urandom_range(1, 4), 1'b0, 1'b1);
            else if (kind < 88)
                send_control(CMD_EMPTY,
                             ($urandom_range(0, 3) == 0)
                             ? $urandom_range(STAGING_BYTES_DEF - 1, STAGING_BYTES_DEF + 2)
                             : $urandom_range(0, OFFSET_MAX));
            else if (kind < 95)
            begin
                // partial chunk cut short by another command
                send_chunk($urandom_range(0, 200), $urandom_range(1, 10), 1'b0, 1'b0);
                case ($urandom_range(0, 2))
                    0:       send_control(CMD_BEGIN, $urandom_range(0, OFFSET_MAX));
                    1:       send_control(CMD_CANCEL, $urandom_range(0, OFFSET_MAX));
                    default: send_control(CMD_EMPTY, $urandom_range(0, OFFSET_MAX));
                endcase
            end
            else
            begin
                // chunk refused while closed, then reopen
                send_control(CMD_CANCEL, $urandom_range(0, OFFSET_MAX));
                send_chunk($urandom_range(0, 100), $urandom_range(1, 4), 1'b0, 1'b1);
                send_control(CMD_BEGIN, $urandom_range(0, OFFSET_MAX));
            end
        end
    endtask

    // cover the whole buffer in order, then revisit it once complete
    task automatic sweep_session();
        int unsigned pos;
        int unsigned len;
        send_control(CMD_BEGIN, $urandom_range(0, OFFSET_MAX));
        refresh_image();
        pos = 0;
        while (pos < STAGING_BYTES_DEF)
        begin
            len = $urandom_range(1, MAX_CHUNK_BYTES_DEF);
            if (len > STAGING_BYTES_DEF - pos)
                len = STAGING_BYTES_DEF - pos;
            send_chunk(pos, len, 1'b0, 1'b1);
            pos += len;
        end
        repeat (6)
        begin
            len = $urandom_range(1, 16);
            send_chunk($urandom_range(0, STAGING_BYTES_DEF - len), len,
                       $urandom_range(0, 2) == 0, 1'b1);
        end
        send_control(CMD_EMPTY, STAGING_BYTES_DEF);
    endtask

    // result side: check each transfer, then pick the next ready level
    initial
    begin
        int            stall_left;
        chunk_result_t got;
        m_tready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                got.status   = m_tdata[1:0];
                got.count    = m_tdata[12:2];
                got.complete = m_tdata[13];
                got.active   = m_tdata[14];
                sb.check_result(got);
            end
            if (holding === 1'b1)
                m_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                m_tready <= (stall_left == 0);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // one long hold-off of the result side while chunks keep coming
    initial
    begin
        holding = 1'b0;
        do
            @(posedge clk);
        while (items_sent < HOLD_AT_ITEM);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_chunk_reassembly_with_conflict_check_top NOT OK");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        int s;
        sb         = new();
        items_sent = 0;
        no_idle    = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_BEGIN;
        s_tlast    = 1'b0;
        refresh_image();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // closed after reset; check order puts not active before range
        send_item(CMD_BYTE, 11'd0, 8'hFF, 1'b1);
        send_item(CMD_EMPTY, 11'd2047, 8'h00, 1'b0);
        send_item(CMD_CANCEL, 11'd0, 8'h00, 1'b1);
        send_item(CMD_BYTE, 11'd2047, 8'h00, 1'b0);
        send_item(CMD_BYTE, 11'd1023, 8'h00, 1'b1);
        // empty chunks at the range boundary
        send_item(CMD_BEGIN, 11'd2047, 8'hFF, 1'b1);
        send_item(CMD_EMPTY, 11'd1024, 8'hFF, 1'b0);
        send_item(CMD_EMPTY, 11'd1025, 8'h00, 1'b1);
        send_item(CMD_EMPTY, 11'd0, 8'h00, 1'b0);
        // last byte, agreeing repeat, conflicting repeat, range ahead of conflict
        send_item(CMD_BYTE, 11'd1023, 8'hFF, 1'b1);
        send_item(CMD_BYTE, 11'd1023, 8'hFF, 1'b1);
        send_item(CMD_BYTE, 11'd1023, 8'h00, 1'b1);
        send_item(CMD_BYTE, 11'd0, 8'h00, 1'b0);
        send_item(CMD_BYTE, 11'd1023, 8'h00, 1'b1);
        send_item(CMD_BYTE, 11'd0, 8'h00, 1'b1);
        // partial chunks dropped by cancel, empty and begin
        send_item(CMD_BYTE, 11'd2047, 8'hAA, 1'b0);
        send_item(CMD_CANCEL, 11'd1024, 8'h55, 1'b0);
        send_item(CMD_BYTE, 11'd0, 8'h12, 1'b1);
        send_item(CMD_BEGIN, 11'd0, 8'h00, 1'b0);
        send_item(CMD_BYTE, 11'd1, 8'h55, 1'b0);
        send_item(CMD_EMPTY, 11'd5, 8'h00, 1'b1);
        send_item(CMD_BYTE, 11'd3, 8'h11, 1'b0);
        send_item(CMD_BEGIN, 11'd7, 8'h00, 1'b1);
        send_item(CMD_BYTE, 11'd0, 8'h22, 1'b1);
        wait_drained();

        // random sessions, one of them filling the whole buffer
        for (s = 0; items_sent < ITEM_TARGET; s++)
        begin
            no_idle = (s % 6 == 1);
            if (s == 4)
                wait_drained();
            if (s == 2)
                sweep_session();
            else
                random_session();
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.failures++;
        if (sb.failures == 0)
            $display("tb_chunk_reassembly_with_conflict_check_top OK");
        else
            $display("tb_chunk_reassembly_with_conflict_check_top NOT OK");
        $finish;
    end

endmodule
